// ===== sv/ksit_pkg.sv =====
// Shared types and constants for the keyed sequence id table.
// Used by ksit_mem, ksit_ctrl and keyed_sequence_id_table_unit; no dependencies.
package ksit_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned SEQ_W       = 16;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ENTRIES_DEF = 64;

  // Request codes; code 3 is unused and yields a failed result
  typedef enum logic [OP_W-1:0] {
    OP_GENERATE = 2'd0,
    OP_QUERY    = 2'd1,
    OP_DELETE   = 2'd2
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_SCAN  = 2'd2,
    ST_WRITE = 2'd3
  } state_e;

  // One table entry as stored in the memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] cnt;
  } entry_t;

  // One result transaction
  typedef struct packed {
    logic             ok;
    logic [SEQ_W-1:0] seq;
  } result_t;

endpackage

// ===== sv/ksit_mem.sv =====
// Single-port-write, single-port-read table memory with a registered read.
// Depends on ksit_pkg for the entry type.
module ksit_mem #(
  parameter int unsigned DEPTH = ksit_pkg::ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  ksit_pkg::entry_t     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output ksit_pkg::entry_t     rd_data_o
);

  ksit_pkg::entry_t mem_q [DEPTH];
  ksit_pkg::entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/ksit_ctrl.sv =====
// Sequencer for the table: clearing pass, linear scan, read-modify-write.
// Depends on ksit_pkg; drives the ports of ksit_mem.
module ksit_ctrl #(
  parameter int unsigned ENTRIES = ksit_pkg::ENTRIES_DEF,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request side
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ksit_pkg::OP_W-1:0]  op_i,
  input  logic [ksit_pkg::KEY_W-1:0] key_id_i,
  // result side
  input  logic                       out_free_i,
  output logic                       push_o,
  output ksit_pkg::result_t          res_o,
  // memory
  output logic                       wr_en_o,
  output logic [AW-1:0]              wr_addr_o,
  output ksit_pkg::entry_t           wr_data_o,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  ksit_pkg::entry_t           rd_data_i
);

  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  ksit_pkg::state_e state_q, state_d;

  logic [AW-1:0]              addr_q;
  logic [ksit_pkg::OP_W-1:0]  op_q;
  logic [ksit_pkg::KEY_W-1:0] key_q;
  logic                       found_q;
  logic [AW-1:0]              hit_idx_q;
  logic [ksit_pkg::SEQ_W-1:0] cnt_q;
  logic                       free_q;
  logic [AW-1:0]              free_idx_q;

  logic accept;
  logic at_last;
  logic rd_hit;
  logic rd_free;

  assign accept  = in_valid_i && in_ready_o;
  assign at_last = (addr_q == LAST);
  assign rd_hit  = rd_data_i.valid && (rd_data_i.key == key_q);
  assign rd_free = !rd_data_i.valid;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ksit_pkg::ST_CLEAR: if (at_last) state_d = ksit_pkg::ST_IDLE;
      ksit_pkg::ST_IDLE:  if (accept) state_d = ksit_pkg::ST_SCAN;
      ksit_pkg::ST_SCAN:  if (at_last) state_d = ksit_pkg::ST_WRITE;
      ksit_pkg::ST_WRITE: if (out_free_i) state_d = ksit_pkg::ST_IDLE;
      default:            state_d = ksit_pkg::ST_CLEAR;
    endcase
  end

  // Outputs: memory accesses and the result
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    res_o      = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = addr_q;
    wr_data_o  = '0;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;
    unique case (state_q)
      ksit_pkg::ST_CLEAR: begin
        wr_en_o = 1'b1;
      end
      ksit_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_en_o    = accept;
      end
      ksit_pkg::ST_SCAN: begin
        // prefetch the next entry while the current one is compared
        rd_en_o   = !at_last;
        rd_addr_o = addr_q + AW'(1);
      end
      ksit_pkg::ST_WRITE: begin
        push_o = out_free_i;
        case (op_q)
          ksit_pkg::OP_GENERATE: begin
            if (found_q) begin
              res_o.ok      = 1'b1;
              res_o.seq     = cnt_q;
              wr_en_o       = out_free_i;
              wr_addr_o     = hit_idx_q;
              wr_data_o     = '{valid: 1'b1, key: key_q,
                                cnt: cnt_q + ksit_pkg::SEQ_W'(1)};
            end else if (free_q) begin
              res_o.ok      = 1'b1;
              wr_en_o       = out_free_i;
              wr_addr_o     = free_idx_q;
              wr_data_o     = '{valid: 1'b1, key: key_q, cnt: ksit_pkg::SEQ_W'(1)};
            end
          end
          ksit_pkg::OP_QUERY: begin
            if (found_q) begin
              res_o.ok  = 1'b1;
              res_o.seq = cnt_q;
            end
          end
          ksit_pkg::OP_DELETE: begin
            if (found_q) begin
              res_o.ok  = 1'b1;
              wr_en_o   = out_free_i;
              wr_addr_o = hit_idx_q;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // State and scan address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ksit_pkg::ST_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ksit_pkg::ST_CLEAR,
        ksit_pkg::ST_SCAN: addr_q <= at_last ? '0 : addr_q + AW'(1);
        default:           addr_q <= '0;
      endcase
    end
  end

  // Latch the request and track the first match and first free entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (accept) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (state_q == ksit_pkg::ST_SCAN) begin
      if (rd_hit) found_q <= 1'b1;
      if (rd_free) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      key_q <= key_id_i;
    end
    if (state_q == ksit_pkg::ST_SCAN) begin
      if (rd_hit && !found_q) begin
        hit_idx_q <= addr_q;
        cnt_q     <= rd_data_i.cnt;
      end
      if (rd_free && !free_q) begin
        free_idx_q <= addr_q;
      end
    end
  end

endmodule

// ===== sv/keyed_sequence_id_table_unit.sv =====
// Keyed sequence id table: top level with the table memory, the sequencer
// and the result register. Depends on ksit_pkg, ksit_mem and ksit_ctrl.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o, op_i, key_id_i): generate the
//   next id for a key, query its counter, or delete it. Every request gives
//   exactly one result on the result channel (out_valid_o/out_ready_i,
//   ok_o, seq_id_o).
//   Each request reads the whole table once, one entry per cycle through the
//   memory's read port (acceptance, then one compare per entry), then enters
//   the write state, which updates the table for a successful generate or
//   delete; its result appears in the output register the cycle after it.
//   The lowest matching entry wins; generate on a miss claims the lowest free
//   entry.
//   After reset the block clears the table, one entry per cycle, with
//   in_ready_o low. A result waiting in the output register
//   does not block the next request; only the write-back of a later request
//   holds until the receiver takes the earlier result.
module keyed_sequence_id_table_unit #(
  parameter int unsigned ENTRIES = ksit_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ksit_pkg::OP_W-1:0]  op_i,
  input  logic [ksit_pkg::KEY_W-1:0] key_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       ok_o,
  output logic [ksit_pkg::SEQ_W-1:0] seq_id_o
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  ksit_pkg::entry_t  wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  ksit_pkg::entry_t  rd_data;

  logic              out_free;
  logic              push;
  ksit_pkg::result_t res;

  logic              out_valid_q;
  ksit_pkg::result_t res_q;

  ksit_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ksit_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .key_id_i   (key_id_i),
    .out_free_i (out_free),
    .push_o     (push),
    .res_o      (res),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  // Output register: free when empty or drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= push;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = res_q.ok;
  assign seq_id_o    = res_q.seq;

endmodule

// ===== sim/keyed_sequence_id_table_unit_checker.sv =====
// Checker for the keyed sequence id table: mirrors the table, predicts each result
// and compares it with what the block returns. Depends on ksit_pkg.
module keyed_sequence_id_table_unit_checker #(
  parameter int unsigned ENTRIES = ksit_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [ksit_pkg::OP_W-1:0]  op_i,
  input  logic [ksit_pkg::KEY_W-1:0] key_id_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       ok_i,
  input  logic [ksit_pkg::SEQ_W-1:0] seq_id_i,
  output int                         fail_cnt_o,
  output int                         owed_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One outstanding request and the id it should return
  typedef struct {
    logic [ksit_pkg::OP_W-1:0]  op;
    logic [ksit_pkg::KEY_W-1:0] key;
    ksit_pkg::result_t          res;
  } owed_id_t;

  logic                       mir_valid [ENTRIES];
  logic [ksit_pkg::KEY_W-1:0] mir_key   [ENTRIES];
  logic [ksit_pkg::SEQ_W-1:0] mir_cnt   [ENTRIES];
  owed_id_t                   ids_owed_q[$];

  initial begin
    fail_cnt_o = 0;
    owed_cnt_o = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      mir_valid[i] = 1'b0;
      mir_key[i]   = '0;
      mir_cnt[i]   = '0;
    end
  end

  // Apply one request to the mirrored table and return the id it yields
  function automatic ksit_pkg::result_t step_id_table(
    input logic [ksit_pkg::OP_W-1:0]  op,
    input logic [ksit_pkg::KEY_W-1:0] key
  );
    ksit_pkg::result_t r;
    int                hit;
    int                free_slot;
    r         = '0;
    hit       = -1;
    free_slot = -1;
    // scan downward so the lowest matching / free slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (mir_valid[i] && mir_key[i] == key) hit = i;
      if (!mir_valid[i]) free_slot = i;
    end
    case (op)
      ksit_pkg::OP_GENERATE: begin
        if (hit >= 0) begin
          r.ok         = 1'b1;
          r.seq        = mir_cnt[hit];
          mir_cnt[hit] = mir_cnt[hit] + 1'b1;
        end else if (free_slot >= 0) begin
          r.ok               = 1'b1;
          mir_valid[free_slot] = 1'b1;
          mir_key[free_slot]   = key;
          mir_cnt[free_slot]   = ksit_pkg::SEQ_W'(1);
        end
      end
      ksit_pkg::OP_QUERY: begin
        if (hit >= 0) begin
          r.ok  = 1'b1;
          r.seq = mir_cnt[hit];
        end
      end
      ksit_pkg::OP_DELETE: begin
        if (hit >= 0) begin
          r.ok           = 1'b1;
          mir_valid[hit] = 1'b0;
          mir_key[hit]   = '0;
          mir_cnt[hit]   = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Count a failure; print only the first few
  task automatic report_fail(input string msg);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // Check the returned transaction first, then record the new request
  always @(posedge clk_i) begin
    owed_id_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (ids_owed_q.size() == 0) begin
          report_fail($sformatf("result ok=%0b seq_id=%0d with no request outstanding",
                                ok_i, seq_id_i));
        end else begin
          want = ids_owed_q.pop_front();
          if (ok_i !== want.res.ok)
            report_fail($sformatf("ok for op=%0d key=%h: expected %0b, got %0b",
                                  want.op, want.key, want.res.ok, ok_i));
          if (seq_id_i !== want.res.seq)
            report_fail($sformatf("seq_id for op=%0d key=%h: expected %0d, got %0d",
                                  want.op, want.key, want.res.seq, seq_id_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        want.op  = op_i;
        want.key = key_id_i;
        want.res = step_id_table(op_i, key_id_i);
        ids_owed_q.push_back(want);
      end
    end
    owed_cnt_o = ids_owed_q.size();
  end

endmodule

// ===== sim/keyed_sequence_id_table_unit_tb.sv =====
// Testbench top for keyed_sequence_id_table_unit: clock, reset, request and
// result stimulus, and the verdict. Depends on ksit_pkg and the checker module.
module keyed_sequence_id_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned  TABLE_ENTRIES    = ksit_pkg::ENTRIES_DEF;
  localparam logic [ksit_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int           POOL_N           = 80;
  localparam int           RAND_ITEMS       = 1380;
  localparam int           HOLD_AT          = 300;
  localparam int           QUIET_AT         = RAND_ITEMS * 85 / 100;
  localparam int           LONG_HOLD_CYCLES = 500;
  localparam int           DRAIN_CYCLES     = 200;
  localparam int           CYCLE_LIMIT      = 1000000;

  typedef enum {EP_FILL, EP_MIX, EP_PURGE, EP_NOISE} episode_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [ksit_pkg::OP_W-1:0]  op_i;
  logic [ksit_pkg::KEY_W-1:0] key_id_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic                       ok_o;
  logic [ksit_pkg::SEQ_W-1:0] seq_id_o;

  int                         fail_cnt;
  int                         owed_cnt;
  int                         cycle_cnt = 0;
  bit                         idle_en = 1'b1;
  bit                         long_hold_req = 1'b0;
  bit                         long_hold_done = 1'b0;
  logic [ksit_pkg::KEY_W-1:0] key_pool [POOL_N];

  keyed_sequence_id_table_unit #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .key_id_i    (key_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .seq_id_o    (seq_id_o)
  );

  keyed_sequence_id_table_unit_checker #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .op_i        (op_i),
    .key_id_i    (key_id_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_i        (ok_o),
    .seq_id_i    (seq_id_o),
    .fail_cnt_o  (fail_cnt),
    .owed_cnt_o  (owed_cnt)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("keyed_sequence_id_table_unit verification failed");
      $finish;
    end
  end

  // Result side: random ready bursts, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Offer one request transaction, with an optional idle burst before it
  task automatic send_req(input logic [ksit_pkg::OP_W-1:0] op,
                          input logic [ksit_pkg::KEY_W-1:0] key);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_id_i   <= key;
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);
  endtask

  initial begin
    episode_e                   ep;
    int                         pick;
    int                         roll;
    int                         ep_len;
    int                         base;
    int                         focus;
    int                         rand_cnt;
    logic [ksit_pkg::OP_W-1:0]  op;
    logic [ksit_pkg::KEY_W-1:0] key;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    op_i       <= ksit_pkg::OP_GENERATE;
    key_id_i   <= '0;
    rand_cnt   = 0;

    // Build the key pool: corner keys, random keys, and one-bit neighbors
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h1;
    key_pool[3] = 64'h8000_0000_0000_0000;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = {$urandom(), $urandom()};
    for (int i = 4; i < 12; i++)
      key_pool[i] = key_pool[i + 20] ^ (64'd1 << $urandom_range(0, 63));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, hits, misses, slot reuse, unused code
    send_req(ksit_pkg::OP_QUERY,    64'h0);
    send_req(ksit_pkg::OP_DELETE,   64'h0);
    send_req(ksit_pkg::OP_GENERATE, 64'h0);
    send_req(ksit_pkg::OP_GENERATE, 64'h0);
    send_req(ksit_pkg::OP_GENERATE, 64'h0);
    send_req(ksit_pkg::OP_QUERY,    64'h0);
    send_req(ksit_pkg::OP_GENERATE, '1);
    send_req(ksit_pkg::OP_GENERATE, 64'h8000_0000_0000_0000);
    send_req(ksit_pkg::OP_GENERATE, 64'h1);
    send_req(ksit_pkg::OP_QUERY,    64'h1);
    send_req(ksit_pkg::OP_DELETE,   64'h0);
    send_req(ksit_pkg::OP_QUERY,    64'h0);
    send_req(ksit_pkg::OP_GENERATE, 64'h1);
    send_req(ksit_pkg::OP_GENERATE, 64'h0);
    send_req(OP_RESERVED,           '1);
    send_req(ksit_pkg::OP_QUERY,    '1);
    send_req(ksit_pkg::OP_DELETE,   '1);
    send_req(ksit_pkg::OP_DELETE,   '1);
    send_req(OP_RESERVED,           64'h0);
    send_req(ksit_pkg::OP_GENERATE, 64'h5555_5555_5555_5555);
    send_req(ksit_pkg::OP_QUERY,    64'hAAAA_AAAA_AAAA_AAAA);
    send_req(ksit_pkg::OP_DELETE,   64'h8000_0000_0000_0000);
    send_req(ksit_pkg::OP_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA);

    // Random: episodes of fills, mixed traffic on a pool, purges and noise
    while (rand_cnt < RAND_ITEMS) begin
      pick   = $urandom_range(0, 9);
      if (pick < 2)      ep = EP_FILL;
      else if (pick < 7) ep = EP_MIX;
      else if (pick < 8) ep = EP_PURGE;
      else               ep = EP_NOISE;
      ep_len = (ep == EP_FILL) ? $urandom_range(40, POOL_N) : $urandom_range(8, 40);
      base   = $urandom_range(0, POOL_N - 1);
      focus  = $urandom_range(2, POOL_N - 1);
      for (int n = 0; n < ep_len && rand_cnt < RAND_ITEMS; n++) begin
        case (ep)
          EP_FILL: begin
            op  = ksit_pkg::OP_GENERATE;
            key = key_pool[(base + n) % POOL_N];
          end
          EP_MIX: begin
            roll = $urandom_range(0, 99);
            op   = (roll < 55) ? ksit_pkg::OP_GENERATE :
                   (roll < 80) ? ksit_pkg::OP_QUERY :
                   (roll < 95) ? ksit_pkg::OP_DELETE : OP_RESERVED;
            key  = key_pool[$urandom_range(0, focus)];
          end
          EP_PURGE: begin
            op  = ksit_pkg::OP_DELETE;
            key = key_pool[(base + n) % POOL_N];
          end
          default: begin
            op  = ksit_pkg::OP_W'($urandom_range(0, 3));
            key = ($urandom_range(0, 1) == 1) ? {$urandom(), $urandom()}
                                              : key_pool[$urandom_range(0, POOL_N - 1)];
          end
        endcase
        if (rand_cnt == HOLD_AT) long_hold_req = 1'b1;
        if (rand_cnt == QUIET_AT) idle_en = 1'b0;
        send_req(op, key);
        rand_cnt++;
      end
    end

    // Drain: wait for every owed result and idle a while, then give the verdict
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("keyed_sequence_id_table_unit verification clean");
    end else begin
      $display("keyed_sequence_id_table_unit verification failed");
    end
    $finish;
  end

endmodule
